FILE: design/fixed_block_free_list_pool_assert.svh
// Assertion helpers for the block pool. Both sample on i_clk and are
// switched off while i_rst_n is low.
`ifndef FIXED_BLOCK_FREE_LIST_POOL_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_POOL_ASSERT_SVH

// Same-cycle implication
`define FBP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define FBP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/fbp_pkg.sv
package fbp_pkg;

    // Fixed field widths
    localparam int CNT_W  = 8;
    localparam int SIZE_W = 13;
    localparam int LIM_W  = 20;   // count * size always stays below 2**20
    localparam int OUT_W  = 20;

    localparam logic [CNT_W-1:0]  END_MARK   = 8'd255;
    localparam logic [SIZE_W-1:0] SIZE_LIMIT = 13'd4096;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd8;

    // Input kind codes
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_IDX_COUNT = 1'b0;
    localparam logic CFG_IDX_SIZE  = 1'b1;

    // Command queue between front and back
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NONE_USED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_RANGE = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [CNT_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [SIZE_W-1:0] size;
        logic [LIM_W-1:0]  limit;
    } t_cfg;

    typedef struct packed {
        logic             pool_empty;
        logic             pool_full;
        logic [CNT_W-1:0] used_blocks;
        logic [OUT_W-1:0] block_offset;
        t_status          status;
    } t_result;

endpackage

FILE: design/fbp_front.sv
module fbp_front #(
    parameter int OFFSET_BITS = 20
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  fbp_pkg::t_cfg          i_cfg,
    input  logic                   i_s_valid,
    output logic                   o_s_ready,
    input  logic                   i_kind,
    input  logic [OFFSET_BITS-1:0] i_offset,
    output logic                   o_push,
    output fbp_pkg::t_cmd          o_cmd,
    input  logic                   i_q_full
);
    import fbp_pkg::*;

    localparam int CW = (OFFSET_BITS > LIM_W) ? OFFSET_BITS : LIM_W;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate          r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [LIM_W-1:0] r_rem, n_rem;
    logic [2:0]       r_bit, n_bit;
    logic [CNT_W-1:0] r_quo, n_quo;

    logic [CW-1:0]    wide_ofs;
    logic [CW-1:0]    wide_lim;
    logic             out_of_range;
    logic [LIM_W-1:0] trial;
    logic             fits;

    // Range check against count * size
    assign wide_ofs     = CW'(i_offset);
    assign wide_lim     = CW'(i_cfg.limit);
    assign out_of_range = wide_ofs >= wide_lim;

    // Restoring divide, one quotient bit per cycle from bit 7 down
    assign trial = LIM_W'(i_cfg.size) << r_bit;
    assign fits  = r_rem >= trial;

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_rem   = r_rem;
        n_bit   = r_bit;
        n_quo   = r_quo;
        case (r_state)
            F_IDLE: begin
                if (i_s_valid) begin
                    if (i_kind == KIND_ALLOC) begin
                        n_cmd   = '{kind: CMD_ALLOC, idx: '0};
                        n_state = F_PUSH;
                    end else if (out_of_range) begin
                        n_cmd   = '{kind: CMD_RANGE, idx: '0};
                        n_state = F_PUSH;
                    end else begin
                        n_rem   = wide_ofs[LIM_W-1:0];
                        n_bit   = 3'd7;
                        n_quo   = '0;
                        n_state = F_DIV;
                    end
                end
            end
            F_DIV: begin
                if (fits) begin
                    n_rem = r_rem - trial;
                    n_quo = r_quo | (CNT_W'(1) << r_bit);
                end
                if (r_bit == 3'd0) begin
                    n_cmd   = '{kind: CMD_FREE, idx: n_quo};
                    n_state = F_PUSH;
                end else begin
                    n_bit = r_bit - 3'd1;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_rem <= n_rem;
        r_bit <= n_bit;
        r_quo <= n_quo;
    end

    assign o_s_ready = r_state == F_IDLE;
    assign o_push    = (r_state == F_PUSH) && !i_q_full;
    assign o_cmd     = r_cmd;

endmodule

FILE: design/fbp_queue.sv
module fbp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fbp_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output fbp_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import fbp_pkg::*;

    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW = $clog2(QDEPTH + 1);

    t_cmd           r_slot [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_cnt;

    assign o_full  = r_cnt == QCW'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_slot[r_rp];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QAW'(QDEPTH - 1)) ? '0 : r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == QAW'(QDEPTH - 1)) ? '0 : r_rp + QAW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule

FILE: design/fbp_back.sv
`include "fixed_block_free_list_pool_assert.svh"

module fbp_back #(
    parameter int MAX_BLOCKS  = 255,
    parameter int OFFSET_BITS = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rebuild,
    input  fbp_pkg::t_cfg    i_cfg,
    input  logic             i_q_valid,
    input  fbp_pkg::t_cmd    i_cmd,
    output logic             o_pop,
    output logic             o_m_valid,
    input  logic             i_m_ready,
    output fbp_pkg::t_result o_result
);
    import fbp_pkg::*;

    localparam int               AW    = $clog2(MAX_BLOCKS);
    localparam logic [CNT_W-1:0] MAX_B = CNT_W'(MAX_BLOCKS);
    localparam logic [OUT_W-1:0] OUT_MASK = (OFFSET_BITS >= OUT_W) ? {OUT_W{1'b1}} :
                                            OUT_W'((64'd1 << OFFSET_BITS) - 64'd1);

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_LINK = 2'b10
    } t_bstate;

    t_bstate               r_state, n_state;
    logic [CNT_W-1:0]      r_head, n_head;
    logic [CNT_W-1:0]      r_used, n_used;
    logic                  r_out_valid, n_out_valid;
    t_result               r_out, n_out;

    // Link store; an entry not yet written since the last rebuild reads as
    // its chained default
    logic [CNT_W-1:0]      r_link [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] r_vld;
    logic [CNT_W-1:0]      r_rd_data;
    logic                  r_rd_vld;

    logic                  head_ok;
    logic                  idx_ok;
    logic                  rd_en;
    logic                  wr_en;
    logic [CNT_W-1:0]      dflt_link;
    logic [CNT_W-1:0]      link_val;
    logic [CNT_W+SIZE_W-1:0] product;
    logic [OUT_W-1:0]      alloc_ofs;
    logic [CNT_W-1:0]      used_inc;
    logic [CNT_W-1:0]      used_dec;

    function automatic logic head_end(input logic [CNT_W-1:0] h);
        return (h == END_MARK) || (h >= MAX_B);
    endfunction

    function automatic t_result make_result(input t_status st, input logic [OUT_W-1:0] ofs,
                                            input logic [CNT_W-1:0] used,
                                            input logic [CNT_W-1:0] head);
        t_result res;
        res.status       = st;
        res.block_offset = ofs;
        res.used_blocks  = used;
        res.pool_full    = head_end(head);
        res.pool_empty   = used == '0;
        return res;
    endfunction

    assign o_pop   = (r_state == B_IDLE) && i_q_valid && !r_out_valid;
    assign head_ok = !head_end(r_head);
    assign idx_ok  = i_cmd.idx < MAX_B;
    assign rd_en   = o_pop && (i_cmd.kind == CMD_ALLOC) && head_ok;
    assign wr_en   = o_pop && (i_cmd.kind == CMD_FREE) && (r_used != '0) && idx_ok;

    // Popped link: stored value, or the fresh chain i -> i+1 / end
    assign dflt_link = ({1'b0, r_head} + 9'd1 < {1'b0, i_cfg.count}) ?
                       r_head + CNT_W'(1) : END_MARK;
    assign link_val  = r_rd_vld ? r_rd_data : dflt_link;
    assign product   = r_head * i_cfg.size;
    assign alloc_ofs = product[OUT_W-1:0] & OUT_MASK;
    assign used_inc  = r_used + CNT_W'(1);
    assign used_dec  = r_used - CNT_W'(1);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_used      = r_used;
        n_out_valid = r_out_valid && !i_m_ready;
        n_out       = r_out;
        case (r_state)
            B_IDLE: begin
                if (o_pop) begin
                    n_out_valid = 1'b1;
                    case (i_cmd.kind)
                        CMD_ALLOC: begin
                            if (head_ok) begin
                                n_out_valid = 1'b0;
                                n_state     = B_LINK;
                            end else begin
                                n_out = make_result(ST_FULL, '0, r_used, r_head);
                            end
                        end
                        CMD_FREE: begin
                            if (r_used == '0) begin
                                n_out = make_result(ST_NONE_USED, '0, r_used, r_head);
                            end else if (idx_ok) begin
                                n_head = i_cmd.idx;
                                n_used = used_dec;
                                n_out  = make_result(ST_OK, '0, used_dec, i_cmd.idx);
                            end else begin
                                n_out = make_result(ST_OK, '0, r_used, r_head);
                            end
                        end
                        default: begin
                            n_out = make_result(ST_RANGE, '0, r_used, r_head);
                        end
                    endcase
                end
            end
            B_LINK: begin
                n_head      = link_val;
                n_used      = used_inc;
                n_out_valid = 1'b1;
                n_out       = make_result(ST_OK, alloc_ofs, used_inc, link_val);
                n_state     = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Control state; a rebuild restarts the free chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_head      <= '0;
            r_used      <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_rebuild) begin
                r_head <= '0;
                r_used <= '0;
                r_vld  <= '0;
            end else begin
                r_head <= n_head;
                r_used <= n_used;
                if (wr_en) begin
                    r_vld[i_cmd.idx[AW-1:0]] <= 1'b1;
                end
            end
        end
    end

    // Link memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_link[i_cmd.idx[AW-1:0]] <= r_head;
        end
        if (rd_en) begin
            r_rd_data <= r_link[r_head[AW-1:0]];
            r_rd_vld  <= r_vld[r_head[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_m_valid = r_out_valid;
    assign o_result  = r_out;

    `FBP_ASSERT_IMP(a_link_head_real, r_state == B_LINK, (r_head < MAX_B) && !r_out_valid, "link fetch without a real head or with the result slot taken")
    `FBP_ASSERT_NXT(a_free_drops_used, wr_en && !i_rebuild, r_used == $past(used_dec), "free did not lower the used count")
    `FBP_ASSERT_NXT(a_rebuild_clears, i_rebuild, (r_head == '0) && (r_used == '0) && (r_vld == '0), "rebuild left free list state behind")

endmodule

FILE: design/fixed_block_free_list_pool.sv
// Channel   Dir  tdata fields (low bit up)                      tuser
// s_axis    in   offset[OFFSET_BITS-1:0], zero pad to bytes      kind (0 alloc, 1 free)
// m_axis    out  block_offset[19:0], used_blocks[27:20],         status[1:0]
//                pool_full[28], pool_empty[29], zero pad [31:30]
// cfg       in   write enable, index (0 block_count, 1 block_size), 13-bit data
//
// An allocate passes the queue push, the pop with one registered read of the
// link memory, and the result register. A free first passes the 8-step
// restoring divider ahead of the queue; a free rejected by the range check
// skips the divider. The input is blocked while the front holds an item, until
// the front has pushed it into the command queue.
// Reset (synchronous, active low) and every configuration write rebuild the
// free chain by clearing per-entry written flags; no clearing pass.
// The front keeps taking items while the back or the result register stalls,
// until the two-entry command queue is full.
module fixed_block_free_list_pool #(
    parameter int MAX_BLOCKS  = 255,
    parameter int OFFSET_BITS = 20
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // offset, zero padded
    input  logic [((OFFSET_BITS + 7) / 8) * 8-1:0] i_s_axis_tdata,
    // kind
    input  logic                                  i_s_axis_tuser,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // block_offset, used_blocks, pool_full, pool_empty, pad
    output logic [31:0]                           o_m_axis_tdata,
    // status
    output logic [1:0]                            o_m_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_index,
    input  logic [12:0]                           i_cfg_data
);
    import fbp_pkg::*;

    localparam logic [CNT_W-1:0] MAX_B = CNT_W'(MAX_BLOCKS);

    logic [CNT_W-1:0]        r_count;
    logic [SIZE_W-1:0]       r_size;
    logic [CNT_W+SIZE_W-1:0] limit_prod;
    logic [CNT_W-1:0]        cfg_count;
    logic [SIZE_W-1:0]       cfg_size;
    t_cfg                    cfg;

    logic    f_push;
    t_cmd    f_cmd;
    logic    q_full;
    logic    q_valid;
    t_cmd    q_cmd;
    logic    b_pop;
    t_result b_result;

    // Clamp written values into their legal ranges
    always_comb begin
        cfg_count = i_cfg_data[CNT_W-1:0];
        if (cfg_count == '0) begin
            cfg_count = CNT_W'(1);
        end else if (cfg_count > MAX_B) begin
            cfg_count = MAX_B;
        end
        cfg_size = i_cfg_data;
        if (cfg_size == '0) begin
            cfg_size = SIZE_W'(1);
        end else if (cfg_size > SIZE_LIMIT) begin
            cfg_size = SIZE_LIMIT;
        end
    end

    // Pool limit follows the registers in the same cycle
    assign limit_prod = r_count * r_size;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= MAX_B;
            r_size  <= SIZE_RESET;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_IDX_COUNT) begin
                    r_count <= cfg_count;
                end else begin
                    r_size <= cfg_size;
                end
            end
        end
    end

    assign cfg = '{count: r_count, size: r_size, limit: limit_prod[LIM_W-1:0]};

    fbp_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_kind    (i_s_axis_tuser),
        .i_offset  (i_s_axis_tdata[OFFSET_BITS-1:0]),
        .o_push    (f_push),
        .o_cmd     (f_cmd),
        .i_q_full  (q_full)
    );

    fbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (b_pop)
    );

    fbp_back #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rebuild (i_cfg_we),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .o_pop     (b_pop),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_result  (b_result)
    );

    // Pack the result item
    assign o_m_axis_tdata = {2'b00, b_result.pool_empty, b_result.pool_full,
                             b_result.used_blocks, b_result.block_offset};
    assign o_m_axis_tuser = b_result.status;

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import fbp_pkg::*;

    localparam int POOL_MAX = 255;
    localparam int OFS_BITS = 20;
    localparam int MAX_ERR_PRINT = 40;

    // DUT ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic [23:0] i_s_axis_tdata = '0;     // offset[19:0], zero pad [23:20]
    logic        i_s_axis_tuser = 1'b0;   // kind
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] o_m_axis_tdata;          // block_offset[19:0], used_blocks[27:20],
                                          // pool_full[28], pool_empty[29], pad
    logic [1:0]  o_m_axis_tuser;          // status
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [12:0] i_cfg_data = '0;

    // Pool mirror: free chain, usage and configuration
    logic [7:0]  chain_link [POOL_MAX];
    logic [7:0]  chain_head;
    logic [7:0]  blocks_in_use;
    int unsigned pool_count;
    int unsigned pool_size;

    t_result     pending_results [$];
    logic [19:0] live_offsets [$];
    t_result     seen_result;
    t_result     want_result;
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    fixed_block_free_list_pool #(
        .MAX_BLOCKS  (POOL_MAX),
        .OFFSET_BITS (OFS_BITS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Run limit
    initial begin
        #(20_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // Pool mirror
    // ---------------------------------------------------------------

    // Chain every block to the next, last one to the end marker
    function automatic void rebuild_free_chain();
        for (int i = 0; i < POOL_MAX; i++) begin
            chain_link[i] = (i + 1 < pool_count) ? 8'(i + 1) : END_MARK;
        end
        chain_head = '0;
        blocks_in_use = '0;
    endfunction

    function automatic void mirror_reg_write(logic idx, logic [12:0] data);
        int unsigned v;
        if (idx == CFG_IDX_COUNT) begin
            v = data[7:0];
            if (v == 0) v = 1;
            if (v > POOL_MAX) v = POOL_MAX;
            pool_count = v;
        end else begin
            v = data;
            if (v == 0) v = 1;
            if (v > SIZE_LIMIT) v = SIZE_LIMIT;
            pool_size = v;
        end
        rebuild_free_chain();
    endfunction

    // A head outside the pool counts as the end marker
    function automatic bit chain_at_end();
        return (chain_head == END_MARK) || (chain_head >= POOL_MAX);
    endfunction

    // Apply one alloc/free to the mirror and return the expected result
    function automatic t_result pool_step(logic kind, logic [19:0] ofs);
        t_result     r;
        int unsigned idx;
        r = '0;
        r.status = ST_OK;
        if (kind == KIND_ALLOC) begin
            if (chain_at_end()) begin
                r.status = ST_FULL;
            end else begin
                idx = chain_head;
                r.block_offset = 20'(idx * pool_size);
                chain_head = chain_link[idx];
                blocks_in_use = blocks_in_use + 8'd1;
            end
        end else begin
            if (ofs >= pool_count * pool_size) begin
                r.status = ST_RANGE;
            end else if (blocks_in_use == 0) begin
                r.status = ST_NONE_USED;
            end else begin
                // misaligned offsets truncate to their block; no double-free check
                idx = ofs / pool_size;
                if (idx < POOL_MAX) begin
                    chain_link[idx] = chain_head;
                    chain_head = 8'(idx);
                    blocks_in_use = blocks_in_use - 8'd1;
                end
            end
        end
        r.used_blocks = blocks_in_use;
        r.pool_full = chain_at_end();
        r.pool_empty = (blocks_in_use == 0);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------

    // Receiver backpressure
    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            if (fail_count < MAX_ERR_PRINT)
                $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare each result item with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen_result.block_offset = o_m_axis_tdata[19:0];
            seen_result.used_blocks = o_m_axis_tdata[27:20];
            seen_result.pool_full = o_m_axis_tdata[28];
            seen_result.pool_empty = o_m_axis_tdata[29];
            seen_result.status = t_status'(o_m_axis_tuser);
            if (pending_results.size() == 0) begin
                if (fail_count < MAX_ERR_PRINT)
                    $error("unexpected result item: status %0d offset %0d",
                           seen_result.status, seen_result.block_offset);
                fail_count++;
            end else begin
                want_result = pending_results.pop_front();
                check_field("status", want_result.status, seen_result.status);
                check_field("block_offset", want_result.block_offset,
                            seen_result.block_offset);
                check_field("used_blocks", want_result.used_blocks,
                            seen_result.used_blocks);
                check_field("pool_full", want_result.pool_full, seen_result.pool_full);
                check_field("pool_empty", want_result.pool_empty, seen_result.pool_empty);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Send one item; the expectation is formed when the item is accepted
    task automatic send_item(logic kind, logic [19:0] ofs);
        int      gap;
        t_result r;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= kind;
        i_s_axis_tdata <= {4'b0, ofs};
        do @(posedge i_clk); while (!o_s_axis_tready);
        r = pool_step(kind, ofs);
        pending_results.push_back(r);
        if (kind == KIND_ALLOC && r.status == ST_OK)
            live_offsets.push_back(r.block_offset);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic wait_pool_idle();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_pool_reg(logic idx, logic [12:0] data);
        wait_pool_idle();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        mirror_reg_write(idx, data);
        live_offsets.delete();
        repeat (2) @(negedge i_clk);
    endtask

    // Pick a live block, optionally misaligned within it
    task automatic free_live_block();
        int          k;
        logic [19:0] ofs;
        k = $urandom_range(0, live_offsets.size() - 1);
        ofs = live_offsets[k];
        live_offsets.delete(k);
        if ($urandom_range(0, 1))
            ofs = ofs + 20'($urandom_range(0, pool_size - 1));
        send_item(KIND_FREE, ofs);
    endtask

    // Mostly well-formed alloc/free traffic plus stray and double frees
    task automatic run_mixed_traffic(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45 || (r < 80 && live_offsets.size() == 0))
                send_item(KIND_ALLOC, 20'($urandom()));
            else if (r < 80)
                free_live_block();
            else if (r < 90)
                send_item(KIND_FREE, 20'($urandom_range(0, pool_count * pool_size - 1)));
            else
                send_item(KIND_FREE, 20'($urandom()));
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Corner cases: register clamping, full pool, range, misalign, double free
    task automatic test_directed();
        // reset setting: 255 blocks of 8 bytes
        send_item(KIND_ALLOC, 20'hFFFFF);
        send_item(KIND_FREE, 20'hFFFFF);
        send_item(KIND_FREE, 20'd3);
        send_item(KIND_FREE, 20'd0);
        // count 0 with high data bits set, size above the limit
        write_pool_reg(CFG_IDX_COUNT, 13'h1F00);
        write_pool_reg(CFG_IDX_SIZE, 13'h1FFF);
        send_item(KIND_ALLOC, 20'd0);
        send_item(KIND_ALLOC, 20'd0);
        send_item(KIND_FREE, 20'd4096);
        send_item(KIND_FREE, 20'd4095);
        // two blocks, double free loops the chain on itself
        write_pool_reg(CFG_IDX_COUNT, 13'd2);
        send_item(KIND_ALLOC, 20'd0);
        send_item(KIND_ALLOC, 20'd0);
        send_item(KIND_FREE, 20'd4096);
        send_item(KIND_FREE, 20'd8191);
        send_item(KIND_ALLOC, 20'd0);
        send_item(KIND_ALLOC, 20'd0);
        // full count, size 0 acts as 1
        write_pool_reg(CFG_IDX_COUNT, 13'h1FFF);
        write_pool_reg(CFG_IDX_SIZE, 13'd0);
        send_item(KIND_ALLOC, 20'd0);
        send_item(KIND_ALLOC, 20'd0);
        send_item(KIND_FREE, 20'd254);
        send_item(KIND_ALLOC, 20'd0);
        send_item(KIND_FREE, 20'd255);
        send_item(KIND_ALLOC, 20'd0);
    endtask

    // Random traffic over several pool shapes under one idling mode
    task automatic test_mixed_traffic(int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    write_pool_reg(CFG_IDX_COUNT, 13'd255);
                    write_pool_reg(CFG_IDX_SIZE, 13'd4096);
                end
                1: begin
                    write_pool_reg(CFG_IDX_COUNT, 13'd1);
                    write_pool_reg(CFG_IDX_SIZE, 13'd1);
                end
                default: begin
                    write_pool_reg(CFG_IDX_SIZE, 13'($urandom_range(0, 8191)));
                    write_pool_reg(CFG_IDX_COUNT,
                                   {5'($urandom()), 8'($urandom_range(1, 8))});
                end
            endcase
            run_mixed_traffic(105);
        end
    endtask

    // Allocate every block past full, then return all of them
    task automatic test_fill_and_drain();
        send_idle_pct = 12;
        recv_idle_pct = 50;
        write_pool_reg(CFG_IDX_SIZE, 13'($urandom_range(1024, 4096)));
        write_pool_reg(CFG_IDX_COUNT, {5'($urandom()), 8'd255});
        repeat (POOL_MAX + 1) send_item(KIND_ALLOC, 20'($urandom()));
        while (live_offsets.size() != 0) free_live_block();
        send_item(KIND_FREE, 20'($urandom()));
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        pool_count = POOL_MAX;
        pool_size = SIZE_RESET;
        rebuild_free_chain();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        test_directed();
        test_mixed_traffic(12, 50);
        test_mixed_traffic(50, 12);
        test_mixed_traffic(0, 0);
        test_fill_and_drain();

        wait_pool_idle();
        repeat (32) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
